FILE: rtl/core/dpp_pkg.sv
`default_nettype none

package dpp_pkg;

  // width of the millisecond counters
  localparam int unsigned TIME_W = 32;
  // width at which counts are compared with 32-bit limits
  localparam int unsigned CMP_W  = (TIME_W > 32) ? TIME_W : 32;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [DATA_W-1:0] DRAIN_TIMEOUT_RST = DATA_W'(60000);

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_STOP   = 3'd4
  } opcode_t;

  // register indexes, taken from paddr word bits
  typedef enum logic {
    REG_DRAIN_TIMEOUT = 1'b0,
    REG_NONE          = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic              water_empty;
    logic [DATA_W-1:0] bleed_length;
  } cmd_t;

  typedef struct packed {
    logic pump_on;
    logic active;
    logic paused;
    logic bleeding;
    logic finished;
    logic timed_out;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/dpp_if.sv
`default_nettype none

interface dpp_cmd_if;
  import dpp_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic              water_empty;
  logic [DATA_W-1:0] bleed_length;

  modport source (output valid, output opcode, output water_empty, output bleed_length,
                  input ready);
  modport sink   (input valid, input opcode, input water_empty, input bleed_length,
                  output ready);
endinterface

interface dpp_res_if;
  logic valid;
  logic ready;
  logic pump_on;
  logic active;
  logic paused;
  logic bleeding;
  logic finished;
  logic timed_out;

  modport source (output valid, output pump_on, output active, output paused,
                  output bleeding, output finished, output timed_out, input ready);
  modport sink   (input valid, input pump_on, input active, input paused,
                  input bleeding, input finished, input timed_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dpp_seq.sv
`default_nettype none

module dpp_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire dpp_pkg::cmd_t             cmd,
  input  wire logic [dpp_pkg::DATA_W-1:0] drain_timeout,
  output dpp_pkg::status_t               status_next
);
  import dpp_pkg::*;

  logic              cycle_active, cycle_active_next;
  logic              cycle_paused, cycle_paused_next;
  logic              in_bleed, in_bleed_next;
  logic              done_flag, done_flag_next;
  logic              error_flag, error_flag_next;
  logic [TIME_W-1:0] drain_count, drain_count_next;
  logic [TIME_W-1:0] bleed_count, bleed_count_next;
  logic [DATA_W-1:0] bleed_limit, bleed_limit_next;

  function automatic logic [TIME_W-1:0] count_up(input logic [TIME_W-1:0] c);
    count_up = (c == {TIME_W{1'b1}}) ? c : c + TIME_W'(1);
  endfunction

  always_comb begin
    cycle_active_next = cycle_active;
    cycle_paused_next = cycle_paused;
    in_bleed_next     = in_bleed;
    done_flag_next    = done_flag;
    error_flag_next   = error_flag;
    drain_count_next  = drain_count;
    bleed_count_next  = bleed_count;
    bleed_limit_next  = bleed_limit;
    unique case (cmd.opcode)
      OP_TICK: begin
        if (cycle_active && !cycle_paused) begin
          if (!in_bleed) begin
            if (cmd.water_empty) begin
              // the tick that sees empty is not part of the bleed
              in_bleed_next    = 1'b1;
              bleed_count_next = '0;
            end else begin
              drain_count_next = count_up(drain_count);
              if (CMP_W'(drain_count_next) >= CMP_W'(drain_timeout)) begin
                cycle_active_next = 1'b0;
                cycle_paused_next = 1'b0;
                error_flag_next   = 1'b1;
              end
            end
          end else begin
            bleed_count_next = count_up(bleed_count);
            if (CMP_W'(bleed_count_next) >= CMP_W'(bleed_limit)) begin
              cycle_active_next = 1'b0;
              cycle_paused_next = 1'b0;
              done_flag_next    = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        bleed_limit_next  = cmd.bleed_length;
        drain_count_next  = '0;
        bleed_count_next  = '0;
        in_bleed_next     = 1'b0;
        cycle_active_next = 1'b1;
        cycle_paused_next = 1'b0;
        done_flag_next    = 1'b0;
        error_flag_next   = 1'b0;
      end
      OP_PAUSE: begin
        if (cycle_active && !cycle_paused) cycle_paused_next = 1'b1;
      end
      OP_RESUME: begin
        if (cycle_active && cycle_paused) cycle_paused_next = 1'b0;
      end
      OP_STOP: begin
        cycle_active_next = 1'b0;
        cycle_paused_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_next.pump_on   = cycle_active_next && !cycle_paused_next;
    status_next.active    = cycle_active_next;
    status_next.paused    = cycle_paused_next;
    status_next.bleeding  = in_bleed_next;
    status_next.finished  = done_flag_next;
    status_next.timed_out = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_active <= 1'b0;
      cycle_paused <= 1'b0;
      in_bleed     <= 1'b0;
      done_flag    <= 1'b0;
      error_flag   <= 1'b0;
      drain_count  <= '0;
      bleed_count  <= '0;
      bleed_limit  <= '0;
    end else if (step) begin
      cycle_active <= cycle_active_next;
      cycle_paused <= cycle_paused_next;
      in_bleed     <= in_bleed_next;
      done_flag    <= done_flag_next;
      error_flag   <= error_flag_next;
      drain_count  <= drain_count_next;
      bleed_count  <= bleed_count_next;
      bleed_limit  <= bleed_limit_next;
    end
  end

  a_pause_needs_active: assert property (@(posedge clk) disable iff (rst)
    cycle_paused |-> cycle_active)
    else $error("paused without an active cycle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(done_flag && error_flag))
    else $error("finished and timed out together");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (step && cmd.opcode == OP_START) |=>
      (cycle_active && !cycle_paused && !in_bleed && !done_flag && !error_flag))
    else $error("start did not restart the cycle");

  a_done_from_bleed: assert property (@(posedge clk) disable iff (rst)
    (step && !done_flag && done_flag_next) |-> in_bleed)
    else $error("finished outside the bleed phase");

endmodule

`default_nettype wire

FILE: rtl/core/drain_pump_phase_controller.sv
// channel | dir | payload                                            | handshake
// cmd     | in  | opcode, water_empty, bleed_length                  | valid/ready
// res     | out | pump_on, active, paused, bleeding, finished, timed_out | valid/ready
// apb     | in  | drain_timeout at byte address 0                    | psel/penable/pready
//
// one command per cycle while cmd.ready is high; the state updates at the accepting edge and the
// result register shows the state after that command on the next cycle
// cmd.ready is high while the result register is empty or being emptied
// rst is synchronous: state clears, drain_timeout returns to 60000
// a stalled result holds its value; nothing is lost while res.ready is low
`default_nettype none

module drain_pump_phase_controller (
  input  wire logic                       clk,
  input  wire logic                       rst,
  dpp_cmd_if.sink                         cmd,
  dpp_res_if.source                       res,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dpp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [dpp_pkg::DATA_W-1:0] pwdata,
  output logic      [dpp_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import dpp_pkg::*;

  logic [DATA_W-1:0] drain_timeout;
  logic              cmd_take;
  logic              res_valid;
  status_t           res_q;
  status_t           status_next;
  cmd_t              cmd_in;
  reg_idx_t          reg_idx;
  logic              cfg_write;

  // byte lanes are not decoded, word address only
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_DRAIN_TIMEOUT: prdata = drain_timeout;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_timeout <= DRAIN_TIMEOUT_RST;
    end else if (cfg_write && reg_idx == REG_DRAIN_TIMEOUT) begin
      drain_timeout <= pwdata;
    end
  end

  assign cmd.ready = !res_valid || res.ready;
  assign cmd_take  = cmd.valid && cmd.ready;

  assign cmd_in.opcode       = cmd.opcode;
  assign cmd_in.water_empty  = cmd.water_empty;
  assign cmd_in.bleed_length = cmd.bleed_length;

  dpp_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .step          (cmd_take),
    .cmd           (cmd_in),
    .drain_timeout (drain_timeout),
    .status_next   (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (cmd_take) res_q <= status_next;
  end

  assign res.valid     = res_valid;
  assign res.pump_on   = res_q.pump_on;
  assign res.active    = res_q.active;
  assign res.paused    = res_q.paused;
  assign res.bleeding  = res_q.bleeding;
  assign res.finished  = res_q.finished;
  assign res.timed_out = res_q.timed_out;

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> res_valid)
    else $error("accepted command produced no result");

  a_pump_consistent: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_q.pump_on == (res_q.active && !res_q.paused)))
    else $error("pump drive disagrees with cycle state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready) |-> !cmd_take)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
